/* rtl/sac_pkg.sv */
`timescale 1ns / 1ps
package sac_pkg;

    localparam int DEF_MAX_SETS    = 128;
    localparam int DEF_MAX_WAYS    = 8;
    localparam int DEF_STAMP_WIDTH = 32;
    localparam int ADDR_WIDTH      = 32;

    localparam int TAG_W  = 32;
    localparam int CIDX_W = 8;
    localparam int CDAT_W = 8;

    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [CIDX_W-1:0] CFG_OFFSET_BITS = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_INDEX_BITS  = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_WAYS_IN_USE = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] CFG_TAG_SHIFT   = CIDX_W'(3);

    localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [2:0] RST_INDEX_BITS  = 3'd5;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd4;
    localparam logic [4:0] RST_TAG_SHIFT   = 5'd2;
    localparam logic [3:0] MAX_OFFSET_BITS = 4'd8;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] address;
        logic [31:0] carry_tag;
        logic        carry_valid;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] out_tag;
        logic        out_valid;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_rsp;

    typedef struct packed {
        logic [CIDX_W-1:0] index;
        logic [CDAT_W-1:0] data;
    } t_cfg;

endpackage

/* rtl/sac_ifs.sv */
`timescale 1ns / 1ps
interface sac_req_if
    import sac_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sac_rsp_if
    import sac_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sac_cfg_if
    import sac_pkg::*;
();
    logic valid;
    logic ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/set_assoc_cache_lru_tags_top.sv */
`timescale 1ns / 1ps
// set-associative tag store with per-set lru stamps
// channels: i_req takes one access beat (command, address, carry_tag,
//   carry_valid); o_rsp gives one result beat per access (hit, out_tag,
//   out_valid, hit_total, miss_total); i_cfg writes offset_bits (0),
//   index_bits (1), ways_in_use (2), tag_shift (3), always ready
// flow: a new access is taken only while idle, so never before the last
//   one is done; the accepting edge reads the whole set row from the set
//   memory, the look state compares all ways, picks the hit way or else the
//   lru way and writes the row back; the next access always sees the update
// the output register holds a finished result while the next access is
//   taken; if o_rsp stays stalled the second access waits after its read
// reset: config registers take their defaults, tallies clear, and a
//   per-set row-valid flag clears so that every set reads as all zero
//   until first written; no clearing pass is needed
module set_assoc_cache_lru_tags_top
    import sac_pkg::*;
#(
    parameter int MAX_SETS    = DEF_MAX_SETS,
    parameter int MAX_WAYS    = DEF_MAX_WAYS,
    parameter int STAMP_WIDTH = DEF_STAMP_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sac_req_if.sink   i_req,
    sac_rsp_if.source o_rsp,
    sac_cfg_if.sink   i_cfg
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1) + 1;
    localparam int LEAVES = 1 << WAY_W;
    localparam int NODES  = 2 * LEAVES - 1;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0]               clock;
        logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamps;
        logic [MAX_WAYS-1:0]                  valids;
        logic [MAX_WAYS-1:0][TAG_W-1:0]       tags;
    } t_row;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state;

    logic [3:0] r_cfg_off;
    logic [2:0] r_cfg_idx;
    logic [3:0] r_cfg_ways;
    logic [4:0] r_cfg_shift;

    t_row r_mem [MAX_SETS];
    logic [MAX_SETS-1:0] r_row_ok;
    t_row r_row;

    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic [TAG_W-1:0] r_shifted;
    logic             r_cmd;
    logic             r_cvalid;

    logic [31:0] r_hits;
    logic [31:0] r_misses;
    logic        r_out_valid;
    t_rsp        r_rsp;

    // config port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off   <= RST_OFFSET_BITS;
            r_cfg_idx   <= RST_INDEX_BITS;
            r_cfg_ways  <= RST_WAYS_IN_USE;
            r_cfg_shift <= RST_TAG_SHIFT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_OFFSET_BITS: r_cfg_off   <= i_cfg.data[3:0];
                CFG_INDEX_BITS:  r_cfg_idx   <= i_cfg.data[2:0];
                CFG_WAYS_IN_USE: r_cfg_ways  <= i_cfg.data[3:0];
                CFG_TAG_SHIFT:   r_cfg_shift <= i_cfg.data[4:0];
                default: begin
                end
            endcase
        end
    end

    // address split at accept
    logic             acc;
    logic [31:0]      a_addr;
    logic [3:0]       a_ob;
    logic [31:0]      a_line;
    logic [31:0]      a_setfull;
    logic [SET_W-1:0] a_set;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign a_addr      = i_req.payload.address & ADDR_MASK;
    assign a_ob        = (r_cfg_off > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : r_cfg_off;
    assign a_line      = a_addr >> a_ob;
    assign a_setfull   = a_line & ((32'd1 << r_cfg_idx) - 32'd1);
    assign a_set       = (MAX_SETS > 1) ? a_setfull[SET_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_row     <= r_mem[a_set];
            r_set     <= a_set;
            r_tag     <= a_line >> r_cfg_idx;
            r_shifted <= i_req.payload.carry_tag >> r_cfg_shift;
            r_cmd     <= i_req.payload.command;
            r_cvalid  <= i_req.payload.carry_valid;
        end
    end

    // compare and lru pick
    logic             adv;
    t_row             row;
    t_row             n_row;
    logic [CNT_W-1:0] ways_eff;
    logic [LEAVES-1:0] way_en;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] way;
    logic [TAG_W-1:0] otag;
    logic             ovalid;
    logic [STAMP_WIDTH-1:0] nd_st  [NODES];
    logic                   nd_en  [NODES];
    logic [WAY_W-1:0]       nd_way [NODES];

    assign adv = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);
    assign row = r_row_ok[r_set] ? r_row : '0;

    always_comb begin
        if (r_cfg_ways == 4'd0) begin
            ways_eff = CNT_W'(1);
        end else if (CNT_W'(r_cfg_ways) > CNT_W'(MAX_WAYS)) begin
            ways_eff = CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = CNT_W'(r_cfg_ways);
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < LEAVES; w++) begin
            way_en[w] = (w < MAX_WAYS) && (CNT_W'(w) < ways_eff);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (way_en[w] && row.valids[w] && row.tags[w] == r_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            nd_en[LEAVES-1+i]  = way_en[i];
            nd_way[LEAVES-1+i] = WAY_W'(i);
            nd_st[LEAVES-1+i]  = (i < MAX_WAYS) ? row.stamps[i % MAX_WAYS] : '0;
        end
        for (int n = LEAVES - 2; n >= 0; n--) begin
            if (nd_en[2*n+2] && (!nd_en[2*n+1] || nd_st[2*n+2] < nd_st[2*n+1])) begin
                nd_en[n]  = nd_en[2*n+2];
                nd_way[n] = nd_way[2*n+2];
                nd_st[n]  = nd_st[2*n+2];
            end else begin
                nd_en[n]  = nd_en[2*n+1];
                nd_way[n] = nd_way[2*n+1];
                nd_st[n]  = nd_st[2*n+1];
            end
        end
    end

    assign way = hit ? hit_way : nd_way[0];

    always_comb begin
        n_row  = row;
        otag   = '0;
        ovalid = 1'b0;
        n_row.clock       = row.clock + 1'b1;
        n_row.stamps[way] = row.clock + 1'b1;
        if (r_cmd == CMD_LOOKUP) begin
            otag   = row.tags[way];
            ovalid = row.valids[way];
            if (!hit) begin
                n_row.tags[way]   = r_tag;
                n_row.valids[way] = 1'b1;
            end
        end else begin
            n_row.tags[way]   = r_shifted;
            n_row.valids[way] = r_cvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mem[r_set] <= n_row;
        end
    end

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_ok    <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (adv) begin
                        r_state         <= S_IDLE;
                        r_row_ok[r_set] <= 1'b1;
                        if (hit) begin
                            r_hits <= r_hits + 32'd1;
                        end else begin
                            r_misses <= r_misses + 32'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp.hit        <= hit;
            r_rsp.out_tag    <= otag;
            r_rsp.out_valid  <= ovalid;
            r_rsp.hit_total  <= hit ? r_hits + 32'd1 : r_hits;
            r_rsp.miss_total <= hit ? r_misses : r_misses + 32'd1;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

endmodule
